// ===== rtl/sort_and_search_engine_core_macros.svh =====
// Assertion macros for the port-level checker.
`ifndef SORT_AND_SEARCH_ENGINE_CORE_MACROS_SVH
`define SORT_AND_SEARCH_ENGINE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SSEC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ssec check failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define SSEC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ssec check failed: next-cycle implication");

`endif

// ===== rtl/ssec_pkg.sv =====
// Shared constants, types and codes of the sort and search engine.
package ssec_pkg;

  // Store geometry
  localparam int DEPTH       = 32;
  localparam int MAX_RESULTS = 32;
  localparam int EMIT_MAX    = (DEPTH < MAX_RESULTS) ? DEPTH : MAX_RESULTS;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int POS_W       = 5;
  localparam int VAL_W       = 32;

  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [POS_W-1:0]        pos_t;
  typedef logic signed [VAL_W-1:0] val_t;

  // Request and result kind codes
  localparam logic REQ_LOAD    = 1'b0;
  localparam logic REQ_SEARCH  = 1'b1;
  localparam logic KIND_ELEM   = 1'b0;
  localparam logic KIND_ANSWER = 1'b1;

  // Search launch word from the controller
  typedef struct packed {
    logic start;
    val_t key;
    cnt_t count;
  } srch_req_t;

  // Search completion word back to the controller
  typedef struct packed {
    logic done;
    logic hit;
    idx_t where;
  } srch_stat_t;

endpackage

// ===== rtl/ssec_ram.sv =====
// Value store: one write port, one read port with registered read data.
module ssec_ram (
  input  logic            clk,
  input  logic            we,
  input  ssec_pkg::idx_t  wr_addr,
  input  ssec_pkg::val_t  wr_data,
  input  ssec_pkg::idx_t  rd_addr,
  output ssec_pkg::val_t  rd_data
);

  ssec_pkg::val_t mem [ssec_pkg::DEPTH];

  // Write on request, read every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/ssec_srch.sv =====
// Iterative binary search over the sorted store; each probe reads, then compares.
module ssec_srch (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ssec_pkg::srch_req_t   req_i,
  input  ssec_pkg::val_t        rd_data,
  output ssec_pkg::idx_t        rd_addr,
  output ssec_pkg::srch_stat_t  stat_o
);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_PROBE = 2'd1;
  localparam logic [1:0] PH_CMP   = 2'd2;

  logic [1:0]           phase_r;
  ssec_pkg::cnt_t       lo_r;
  ssec_pkg::cnt_t       end_r;
  ssec_pkg::idx_t       mid_r;
  ssec_pkg::val_t       key_r;
  ssec_pkg::srch_stat_t stat_r;
  ssec_pkg::cnt_t       span;
  ssec_pkg::cnt_t       mid_full;

  // Midpoint of the open range [lo, end): lo + (hi - lo) / 2 with hi = end - 1
  always_comb begin
    span     = end_r - lo_r - ssec_pkg::cnt_t'(1);
    mid_full = lo_r + (span >> 1);
    rd_addr  = mid_full[ssec_pkg::IDX_W-1:0];
  end

  assign stat_o = stat_r;

  // Narrow the range until a hit or an empty range
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      stat_r  <= '0;
    end else begin
      stat_r.done <= 1'b0;
      unique case (phase_r)
        PH_IDLE: begin
          if (req_i.start) begin
            lo_r    <= '0;
            end_r   <= req_i.count;
            key_r   <= req_i.key;
            phase_r <= PH_PROBE;
          end
        end
        PH_PROBE: begin
          if (lo_r < end_r) begin
            mid_r   <= rd_addr;
            phase_r <= PH_CMP;
          end else begin
            stat_r.done  <= 1'b1;
            stat_r.hit   <= 1'b0;
            stat_r.where <= '0;
            phase_r      <= PH_IDLE;
          end
        end
        PH_CMP: begin
          priority if (rd_data == key_r) begin
            stat_r.done  <= 1'b1;
            stat_r.hit   <= 1'b1;
            stat_r.where <= mid_r;
            phase_r      <= PH_IDLE;
          end else if (rd_data > key_r) begin
            end_r   <= ssec_pkg::cnt_t'(mid_r);
            phase_r <= PH_PROBE;
          end else begin
            lo_r    <= ssec_pkg::cnt_t'(mid_r) + ssec_pkg::cnt_t'(1);
            phase_r <= PH_PROBE;
          end
        end
        default: begin
          phase_r <= PH_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/sort_and_search_engine_core.sv =====
// Top level of the sort and search engine: load, bubble sort, emit and search control.
//
// Usage: an input word is taken at a rising edge with start high and busy low.
// A load (in_req_type 0) writes in_value into the next store entry and
// gives no result unless in_is_last is set; loads beyond DEPTH are
// dropped and flag out_overflow for the whole set. A load after a closed set
// starts a new set. The last load sorts the set in the store by bubble sort:
// each pass does one store read and one write per entry, the bubbling
// value held in a register; the engine then emits one sorted word per
// cycle with out_last on the final one. A search (in_req_type 1) on a
// closed set probes the store by binary search, each probe a registered
// memory read, then a compare; a search on an open set answers in the
// next cycle with found low. Results appear for one cycle with out_valid
// high; the receiver cannot stall. busy stays high until the last result
// of a sort has been issued. Reset (rst_n low, synchronous) empties the
// set and stops any sort, emission or search; store contents are not cleared.
module sort_and_search_engine_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_req_type,
  input  logic signed [31:0]    in_value,
  input  logic                  in_is_last,
  output logic                  out_valid,
  output logic                  out_kind,
  output logic signed [31:0]    out_value_res,
  output logic [4:0]            out_position,
  output logic                  out_found,
  output logic                  out_overflow,
  output logic                  out_last
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PASS = 3'd1;
  localparam logic [2:0] ST_LOAD = 3'd2;
  localparam logic [2:0] ST_RUN  = 3'd3;
  localparam logic [2:0] ST_END  = 3'd4;
  localparam logic [2:0] ST_EMIT = 3'd5;
  localparam logic [2:0] ST_SRCH = 3'd6;

  logic [2:0]           state_r;
  ssec_pkg::cnt_t       count_r;
  logic                 closed_r;
  logic                 dropped_r;
  ssec_pkg::cnt_t       len_r;
  ssec_pkg::cnt_t       j_r;
  ssec_pkg::cnt_t       k_r;
  ssec_pkg::val_t       carry_r;
  logic                 pend_r;
  ssec_pkg::idx_t       pend_k_r;
  logic                 pend_last_r;

  logic                 out_valid_r;
  logic                 out_kind_r;
  ssec_pkg::val_t       out_value_r;
  ssec_pkg::pos_t       out_pos_r;
  logic                 out_found_r;
  logic                 out_ovf_r;
  logic                 out_last_r;

  logic                 accept;
  ssec_pkg::cnt_t       cnt_base;
  logic                 drop_base;
  logic                 load_ok;
  ssec_pkg::cnt_t       cnt_new;
  ssec_pkg::cnt_t       emit_n;
  ssec_pkg::cnt_t       j2;
  ssec_pkg::cnt_t       len_m1;
  logic                 smaller;

  logic                 we;
  ssec_pkg::idx_t       wr_addr;
  ssec_pkg::val_t       wr_data;
  ssec_pkg::idx_t       rd_addr;
  ssec_pkg::val_t       rd_data;
  ssec_pkg::idx_t       srch_addr;
  ssec_pkg::srch_req_t  srch_req;
  ssec_pkg::srch_stat_t srch_stat;

  // Handshake and set bookkeeping
  assign busy     = (state_r != ST_IDLE) || pend_r;
  assign accept   = start && !busy;
  assign cnt_base = closed_r ? '0 : count_r;
  assign drop_base = closed_r ? 1'b0 : dropped_r;
  assign load_ok  = cnt_base < ssec_pkg::cnt_t'(ssec_pkg::DEPTH);
  assign cnt_new  = load_ok ? (cnt_base + ssec_pkg::cnt_t'(1)) : cnt_base;
  assign emit_n   = (count_r > ssec_pkg::cnt_t'(ssec_pkg::EMIT_MAX)) ?
                    ssec_pkg::cnt_t'(ssec_pkg::EMIT_MAX) : count_r;
  assign j2       = j_r + ssec_pkg::cnt_t'(2);
  assign len_m1   = len_r - ssec_pkg::cnt_t'(1);
  assign smaller  = rd_data < carry_r;

  // Launch a search only on a closed set
  assign srch_req.start = accept && (in_req_type == ssec_pkg::REQ_SEARCH) && closed_r;
  assign srch_req.key   = in_value;
  assign srch_req.count = count_r;

  // Steer the store ports
  always_comb begin
    we      = 1'b0;
    wr_addr = cnt_base[ssec_pkg::IDX_W-1:0];
    wr_data = in_value;
    rd_addr = '0;
    unique case (state_r)
      ST_IDLE: begin
        we = accept && (in_req_type == ssec_pkg::REQ_LOAD) && load_ok;
      end
      ST_PASS: begin
        rd_addr = '0;
      end
      ST_LOAD: begin
        rd_addr = ssec_pkg::idx_t'(1);
      end
      ST_RUN: begin
        rd_addr = j2[ssec_pkg::IDX_W-1:0];
        we      = 1'b1;
        wr_addr = j_r[ssec_pkg::IDX_W-1:0];
        wr_data = smaller ? rd_data : carry_r;
      end
      ST_END: begin
        we      = 1'b1;
        wr_addr = len_m1[ssec_pkg::IDX_W-1:0];
        wr_data = carry_r;
      end
      ST_EMIT: begin
        rd_addr = k_r[ssec_pkg::IDX_W-1:0];
      end
      ST_SRCH: begin
        rd_addr = srch_addr;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  ssec_ram u_ram (
    .clk     (clk),
    .we      (we),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ssec_srch u_srch (
    .clk     (clk),
    .rst_n   (rst_n),
    .req_i   (srch_req),
    .rd_data (rd_data),
    .rd_addr (srch_addr),
    .stat_o  (srch_stat)
  );

  // Sequence loads, sort passes, emission and searches
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      closed_r    <= 1'b0;
      dropped_r   <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;

      // Drive an emitted word once its store read has returned
      if (pend_r) begin
        out_valid_r <= 1'b1;
        out_kind_r  <= ssec_pkg::KIND_ELEM;
        out_value_r <= rd_data;
        out_pos_r   <= ssec_pkg::pos_t'(pend_k_r);
        out_found_r <= 1'b0;
        out_ovf_r   <= dropped_r;
        out_last_r  <= pend_last_r;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            if (in_req_type == ssec_pkg::REQ_LOAD) begin
              count_r   <= cnt_new;
              dropped_r <= drop_base || !load_ok;
              closed_r  <= in_is_last;
              if (in_is_last) begin
                len_r   <= cnt_new;
                state_r <= ST_PASS;
              end
            end else begin
              // Echo the key now; on a closed set the answer fields follow
              out_value_r <= in_value;
              if (closed_r) begin
                state_r <= ST_SRCH;
              end else begin
                out_valid_r <= 1'b1;
                out_kind_r  <= ssec_pkg::KIND_ANSWER;
                out_pos_r   <= '0;
                out_found_r <= 1'b0;
                out_ovf_r   <= dropped_r;
                out_last_r  <= 1'b1;
              end
            end
          end
        end
        ST_PASS: begin
          if (len_r < ssec_pkg::cnt_t'(2)) begin
            k_r     <= '0;
            state_r <= ST_EMIT;
          end else begin
            state_r <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          carry_r <= rd_data;
          j_r     <= '0;
          state_r <= ST_RUN;
        end
        ST_RUN: begin
          // Keep the larger value bubbling to the right
          if (!smaller) begin
            carry_r <= rd_data;
          end
          if (j2 == len_r) begin
            state_r <= ST_END;
          end else begin
            j_r <= j_r + ssec_pkg::cnt_t'(1);
          end
        end
        ST_END: begin
          len_r   <= len_m1;
          state_r <= ST_PASS;
        end
        ST_EMIT: begin
          if (emit_n == '0) begin
            state_r <= ST_IDLE;
          end else begin
            pend_r      <= 1'b1;
            pend_k_r    <= k_r[ssec_pkg::IDX_W-1:0];
            pend_last_r <= (k_r + ssec_pkg::cnt_t'(1)) == emit_n;
            k_r         <= k_r + ssec_pkg::cnt_t'(1);
            if ((k_r + ssec_pkg::cnt_t'(1)) == emit_n) begin
              state_r <= ST_IDLE;
            end
          end
        end
        ST_SRCH: begin
          if (srch_stat.done) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= ssec_pkg::KIND_ANSWER;
            out_pos_r   <= ssec_pkg::pos_t'(srch_stat.where);
            out_found_r <= srch_stat.hit;
            out_ovf_r   <= dropped_r;
            out_last_r  <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_value_res = out_value_r;
  assign out_position  = out_pos_r;
  assign out_found     = out_found_r;
  assign out_overflow  = out_ovf_r;
  assign out_last      = out_last_r;

endmodule

// ===== rtl/ssec_chk.sv =====
// Port-level checker for the sort and search engine, bound to the top level.
`include "sort_and_search_engine_core_macros.svh"

module ssec_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               in_req_type,
  input logic               in_is_last,
  input logic               out_valid,
  input logic               out_kind,
  input logic [4:0]         out_position,
  input logic               out_found,
  input logic               out_last
);

  logic take;
  logic last_load;
  logic srch_take;
  logic answer_out;
  logic elem_out;

  // Decode accepted words and result kinds
  assign take       = start && !busy;
  assign last_load  = take && (in_req_type == ssec_pkg::REQ_LOAD) && in_is_last;
  assign srch_take  = take && (in_req_type == ssec_pkg::REQ_SEARCH);
  assign answer_out = out_valid && (out_kind == ssec_pkg::KIND_ANSWER);
  assign elem_out   = out_valid && (out_kind == ssec_pkg::KIND_ELEM);

  // A last load must start the sort
  `SSEC_ASSERT_NXT(a_last_load_busy, clk, rst_n, last_load, busy)

  // A search either answers at once or keeps the block busy
  `SSEC_ASSERT_NXT(a_search_progress, clk, rst_n, srch_take, busy || answer_out)

  // A search answer is always the only word of its request
  `SSEC_ASSERT_IMP(a_answer_last, clk, rst_n, answer_out, out_last)

  // A miss reports position zero
  `SSEC_ASSERT_IMP(a_miss_pos, clk, rst_n, answer_out && !out_found, out_position == 5'd0)

  // Sorted words never claim a hit
  `SSEC_ASSERT_IMP(a_elem_nofound, clk, rst_n, elem_out, !out_found)

endmodule

bind sort_and_search_engine_core ssec_chk u_ssec_chk (.*);
